FILE: rtl/tga_pkg.sv
// tga_pkg: decoder phase type, register map and fixed constants
// used by the line decoder top level and its port checker
package tga_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RUN     = 2'd1,
        PH_LITERAL = 2'd2
    } phase_t;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_PIXEL_BYTES = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_RLE_ENABLED = 2'd2;

    localparam logic [7:0] RUN_FLAG   = 8'h80;
    localparam logic [7:0] COUNT_MASK = 8'h7F;
    localparam logic [7:0] MAX_REPEAT = 8'd128;

    localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd1;
    localparam logic [15:0] LINE_WIDTH_RESET  = 16'd1;

endpackage

FILE: rtl/tga_rle_line_decoder.sv
// tga_rle_line_decoder: TGA image-data byte stream to scanline pixels with repeat counts
// depends on tga_pkg for the phase type, register map and constants
//
//  channel   direction  handshake           payload
//  input     in         in_valid/in_stall    data_byte
//  output    out        out_valid/out_stall  pixel_value, repeat_count, line_end,
//                                            overrun_error
//  config    in/out     apb write/read       pixel_bytes, line_width, rle_enabled
//
// one byte is taken every cycle while in_stall is low; a result is offered once its last
// byte has passed through the input register and the result register
// reset clears the registers to pixel_bytes 1, line_width 1, raw mode, line start
// a stalled result holds the result register; the input register then fills and
// in_stall rises in the same cycle, so no byte is lost
module tga_rle_line_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    // pixel results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_value,
    output logic [7:0]  repeat_count,
    output logic        line_end,
    output logic        overrun_error,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [2:0]  pixel_bytes_reg;
    logic [15:0] line_width_reg;
    logic        rle_enabled_reg;

    // decoder state
    tga_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [15:0] line_pos_reg, line_pos_next;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pixel_reg;
    logic [7:0]  out_count_reg;
    logic        out_end_reg;
    logic        out_err_reg;

    logic        advance;
    logic        in_accept;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    logic [2:0]  eff_bytes;
    logic [15:0] eff_width;
    logic [31:0] acc_taken;
    logic        pixel_done;
    logic        take;
    logic        emit_req;
    logic [7:0]  emit_count;
    logic [16:0] emit_pos;
    logic        emit_end;
    logic [7:0]  hdr_count;
    logic [16:0] hdr_end;
    logic        res_valid;
    logic [31:0] res_pixel;
    logic [7:0]  res_count;
    logic        res_end;
    logic        res_err;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        prdata = 32'd0;
        unique case (cfg_index)
            tga_pkg::REG_PIXEL_BYTES: prdata = {29'd0, pixel_bytes_reg};
            tga_pkg::REG_LINE_WIDTH:  prdata = {16'd0, line_width_reg};
            tga_pkg::REG_RLE_ENABLED: prdata = {31'd0, rle_enabled_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg <= tga_pkg::PIXEL_BYTES_RESET;
            line_width_reg  <= tga_pkg::LINE_WIDTH_RESET;
            rle_enabled_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tga_pkg::REG_PIXEL_BYTES: pixel_bytes_reg <= pwdata[2:0];
                tga_pkg::REG_LINE_WIDTH:  line_width_reg  <= pwdata[15:0];
                tga_pkg::REG_RLE_ENABLED: rle_enabled_reg <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    // out-of-range sizes clamp to the nearest legal value
    always_comb
    begin
        if (pixel_bytes_reg == 3'd0)
            eff_bytes = 3'd1;
        else if (pixel_bytes_reg > 3'd4)
            eff_bytes = 3'd4;
        else
            eff_bytes = pixel_bytes_reg;
        eff_width = (line_width_reg == 16'd0) ? 16'd1 : line_width_reg;
    end

    assign acc_taken  = acc_reg | ({24'd0, in_byte_reg} << {byte_index_reg, 3'b000});
    assign pixel_done = ({1'b0, byte_index_reg} + 3'd1) >= eff_bytes;
    assign hdr_count  = (in_byte_reg & tga_pkg::COUNT_MASK) + 8'd1;
    assign hdr_end    = {1'b0, line_pos_reg} + {9'd0, hdr_count};

    always_comb
    begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        byte_index_next = byte_index_reg;
        acc_next        = acc_reg;
        line_pos_next   = line_pos_reg;
        take       = 1'b0;
        emit_req   = 1'b0;
        emit_count = 8'd1;
        res_valid  = 1'b0;
        res_pixel  = 32'd0;
        res_count  = 8'd0;
        res_end    = 1'b0;
        res_err    = 1'b0;

        if (!rle_enabled_reg)
        begin
            phase_next     = tga_pkg::PH_HEADER;
            remaining_next = 8'd0;
            take           = 1'b1;
            emit_req       = pixel_done;
        end
        else
        begin
            unique case (phase_reg)
                tga_pkg::PH_RUN:
                begin
                    take       = 1'b1;
                    emit_req   = pixel_done;
                    emit_count = remaining_reg;
                    if (pixel_done)
                    begin
                        phase_next     = tga_pkg::PH_HEADER;
                        remaining_next = 8'd0;
                    end
                end
                tga_pkg::PH_LITERAL:
                begin
                    take     = 1'b1;
                    emit_req = pixel_done;
                    if (pixel_done)
                    begin
                        if (remaining_reg > 8'd1)
                            remaining_next = remaining_reg - 8'd1;
                        else
                        begin
                            remaining_next = 8'd0;
                            phase_next     = tga_pkg::PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    // packet header, also taken for a stray phase code
                    byte_index_next = 2'd0;
                    acc_next        = 32'd0;
                    if (hdr_end > {1'b0, eff_width})
                    begin
                        phase_next     = tga_pkg::PH_HEADER;
                        remaining_next = 8'd0;
                        line_pos_next  = 16'd0;
                        res_valid      = 1'b1;
                        res_err        = 1'b1;
                    end
                    else
                    begin
                        remaining_next = hdr_count;
                        phase_next = ((in_byte_reg & tga_pkg::RUN_FLAG) != 8'd0)
                                   ? tga_pkg::PH_RUN : tga_pkg::PH_LITERAL;
                    end
                end
            endcase
        end

        emit_pos = {1'b0, line_pos_reg} + {9'd0, emit_count};
        emit_end = emit_pos >= {1'b0, eff_width};

        if (take)
        begin
            acc_next        = acc_taken;
            byte_index_next = pixel_done ? 2'd0 : byte_index_reg + 2'd1;
        end
        if (emit_req)
        begin
            res_valid     = 1'b1;
            res_pixel     = acc_taken;
            res_count     = emit_count;
            res_end       = emit_end;
            acc_next      = 32'd0;
            line_pos_next = emit_end ? 16'd0 : emit_pos[15:0];
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= tga_pkg::PH_HEADER;
            byte_index_reg <= 2'd0;
            acc_reg        <= 32'd0;
            remaining_reg  <= 8'd0;
            line_pos_reg   <= 16'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance)
            begin
                phase_reg      <= phase_next;
                byte_index_reg <= byte_index_next;
                acc_reg        <= acc_next;
                remaining_reg  <= remaining_next;
                line_pos_reg   <= line_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= data_byte;
        if (in_valid_reg && advance && res_valid)
        begin
            out_pixel_reg <= res_pixel;
            out_count_reg <= res_count;
            out_end_reg   <= res_end;
            out_err_reg   <= res_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = out_pixel_reg;
    assign repeat_count  = out_count_reg;
    assign line_end      = out_end_reg;
    assign overrun_error = out_err_reg;

endmodule

FILE: rtl/tga_checker.sv
// tga_checker: port-level checks on the line decoder, attached by bind
// depends on tga_pkg for the repeat limit and on the top level's ports
module tga_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_value,
    input logic [7:0]  repeat_count,
    input logic        line_end,
    input logic        overrun_error
);

    // a stalled transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_value) && $stable(repeat_count))
        else $error("stalled result changed");

    // an overrun result carries no pixel and never ends the line
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overrun_error |->
            pixel_value == 32'd0 && repeat_count == 8'd0 && !line_end)
        else $error("overrun result with pixel data");

    // pixel results always carry a count of one to the packet limit
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overrun_error |->
            repeat_count != 8'd0 && repeat_count <= tga_pkg::MAX_REPEAT)
        else $error("pixel repeat count out of range");

endmodule

bind tga_rle_line_decoder tga_checker u_tga_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_value   (pixel_value),
    .repeat_count  (repeat_count),
    .line_end      (line_end),
    .overrun_error (overrun_error)
);
